[src/sgra_pkg.sv]
package sgra_pkg;

  // Default build values
  localparam int GRID_RES_DEF      = 1024;
  localparam int CORDIC_STAGES_DEF = 16;

  // Field widths
  localparam int GRID_W   = 10;
  localparam int PIX_W    = 12;
  localparam int FRAME_W  = 13;
  localparam int WORD_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Datapath widths
  localparam int CW     = 36;  // CORDIC x/y, signed Q.16 feet
  localparam int ZW     = 28;  // CORDIC angle, signed Q.24 radians
  localparam int AW     = ZW + 1;
  localparam int PW     = 43;  // angle times frame size
  localparam int NW     = 48;  // pixel numerator
  localparam int REM_W  = 39;  // holds up to 4096 * 2pi in Q.24

  // Reciprocal for the cell-to-feet scaling
  localparam int RECIP_SHIFT = 46;
  localparam int RECIP_W     = 43;
  localparam int RECIP_LO_W  = 21;
  localparam int RECIP_HI_W  = RECIP_W - RECIP_LO_W;

  localparam int  ATAN_LEN    = 24;
  localparam int  HALF_PI_Q24 = 26353589;
  localparam longint TWO_PI_Q24 = 64'd105414357;
  localparam int  GAIN_Q16    = 107922;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_AZ_OFFSET    = 3'd2,
    CFG_EL_OFFSET    = 3'd3,
    CFG_MOUNT_HEIGHT = 3'd4,
    CFG_GROUND_SPAN  = 3'd5
  } cfg_idx_t;

  // atan(2^-i) in Q.24
  function automatic logic [23:0] atan_q24(input int i);
    logic [23:0] v;
    unique case (i)
      0:  v = 24'd13176795;
      1:  v = 24'd7778716;
      2:  v = 24'd4110060;
      3:  v = 24'd2086331;
      4:  v = 24'd1047214;
      5:  v = 24'd524117;
      6:  v = 24'd262123;
      7:  v = 24'd131069;
      8:  v = 24'd65536;
      9:  v = 24'd32768;
      10: v = 24'd16384;
      11: v = 24'd8192;
      12: v = 24'd4096;
      13: v = 24'd2048;
      14: v = 24'd1024;
      15: v = 24'd512;
      16: v = 24'd256;
      17: v = 24'd128;
      18: v = 24'd64;
      19: v = 24'd32;
      20: v = 24'd16;
      21: v = 24'd8;
      22: v = 24'd4;
      23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

[src/sgra_cordic.sv]
module sgra_cordic
  import sgra_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter int SBW    = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  output logic                 up_rdy,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic signed [ZW-1:0] in_z,
  input  logic [SBW-1:0]       in_sb,
  output logic                 out_vld,
  input  logic                 dn_rdy,
  output logic signed [CW-1:0] out_x,
  output logic signed [ZW-1:0] out_z,
  output logic [SBW-1:0]       out_sb
);

  logic                 v_r  [STAGES];
  logic signed [CW-1:0] x_r  [STAGES];
  logic signed [CW-1:0] y_r  [STAGES];
  logic signed [ZW-1:0] z_r  [STAGES];
  logic [SBW-1:0]       sb_r [STAGES];

  // stage inputs: entry 0 is the module input
  logic                 vi  [STAGES+1];
  logic signed [CW-1:0] xi  [STAGES+1];
  logic signed [CW-1:0] yi  [STAGES+1];
  logic signed [ZW-1:0] zi  [STAGES+1];
  logic [SBW-1:0]       sbi [STAGES+1];
  logic                 go  [STAGES+1];

  assign vi[0]  = in_vld;
  assign xi[0]  = in_x;
  assign yi[0]  = in_y;
  assign zi[0]  = in_z;
  assign sbi[0] = in_sb;
  assign go[STAGES] = dn_rdy;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] AT = ZW'(atan_q24(i));
    logic signed [CW-1:0] x_nxt, y_nxt, xs, ys;
    logic signed [ZW-1:0] z_nxt;

    assign vi[i+1]  = v_r[i];
    assign xi[i+1]  = x_r[i];
    assign yi[i+1]  = y_r[i];
    assign zi[i+1]  = z_r[i];
    assign sbi[i+1] = sb_r[i];
    // a stage loads when empty or when the one after it moves
    assign go[i] = !v_r[i] || go[i+1];

    always_comb begin
      xs = xi[i] >>> i;
      ys = yi[i] >>> i;
      if (!yi[i][CW-1]) begin
        x_nxt = xi[i] + ys;
        y_nxt = yi[i] - xs;
        z_nxt = zi[i] + AT;
      end else begin
        x_nxt = xi[i] - ys;
        y_nxt = yi[i] + xs;
        z_nxt = zi[i] - AT;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (go[i]) begin
        v_r[i] <= vi[i];
      end
    end

    always_ff @(posedge clk) begin
      if (go[i]) begin
        x_r[i]  <= x_nxt;
        y_r[i]  <= y_nxt;
        z_r[i]  <= z_nxt;
        sb_r[i] <= sbi[i];
      end
    end
  end

  assign up_rdy  = go[0];
  assign out_vld = v_r[STAGES-1];
  assign out_x   = x_r[STAGES-1];
  assign out_z   = z_r[STAGES-1];
  assign out_sb  = sb_r[STAGES-1];

endmodule

[src/sgra_div.sv]
module sgra_div
  import sgra_pkg::*;
#(
  parameter int     DW  = REM_W,
  parameter int     QB  = PIX_W,
  parameter longint DIV = TWO_PI_Q24,
  parameter int     SBW = 22
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  output logic                  up_rdy,
  input  logic [1:0][DW-1:0]    in_n,
  input  logic [SBW-1:0]        in_sb,
  output logic                  out_vld,
  input  logic                  dn_rdy,
  output logic [1:0][QB-1:0]    out_q,
  output logic [SBW-1:0]        out_sb
);

  // two lanes of divide by constant: reciprocal estimate from the top bits,
  // which is low by at most one, then one compare and increment
  localparam int HW = 25;            // dividend bits fed to the estimate
  localparam int LS = DW - HW;       // low dividend bits left out
  localparam int RS = 32;            // reciprocal fraction bits
  localparam int MW = 21;
  localparam int EW = HW + MW;
  localparam longint MUL = (longint'(1) << (LS + RS)) / DIV;
  localparam logic [MW-1:0] RECIP = MW'(MUL);
  localparam logic [DW-1:0] DV    = DW'(DIV);
  localparam int NS = 3;             // estimate, remainder, correct

  logic                 v_r  [NS];
  logic [SBW-1:0]       sb_r [NS];
  logic                 go   [NS+1];

  logic [1:0][DW-1:0]   n0_r, r1_r;
  logic [1:0][QB-1:0]   q0_r, q1_r, q2_r;
  logic [1:0][EW-1:0]   est;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      est[l] = EW'(in_n[l][DW-1:LS]) * EW'(RECIP);
    end
  end

  assign go[NS] = dn_rdy;
  for (genvar i = 0; i < NS; i++) begin : g_ctl
    assign go[i] = !v_r[i] || go[i+1];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (go[i]) begin
        v_r[i] <= (i == 0) ? in_vld : v_r[(i == 0) ? 0 : i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (go[i]) begin
        sb_r[i] <= (i == 0) ? in_sb : sb_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      n0_r <= in_n;
      for (int l = 0; l < 2; l++) begin
        q0_r[l] <= est[l][RS+QB-1:RS];
      end
    end
    if (go[1]) begin
      q1_r <= q0_r;
      for (int l = 0; l < 2; l++) begin
        r1_r[l] <= n0_r[l] - DW'(q0_r[l]) * DV;
      end
    end
    if (go[2]) begin
      for (int l = 0; l < 2; l++) begin
        q2_r[l] <= q1_r[l] + QB'(r1_r[l] >= DV);
      end
    end
  end

  assign up_rdy  = go[0];
  assign out_vld = v_r[NS-1];
  assign out_q   = q2_r;
  assign out_sb  = sb_r[NS-1];

endmodule

[src/spherical_ground_remap_address_unit.sv]
// Channel   Direction  Handshake            Payload
// in_       sink       in_valid / in_stall  grid_x, grid_y
// out_      source     out_valid/out_stall  source_col, source_row, dest_col, dest_row, hit
// cfg_      sink       cfg_wr_en            cfg_index, cfg_wdata
//
// One cell per cycle sustained while out_stall is low; every stage is a register with
// its own valid. A cell passes the front-end stages, the two chained CORDIC passes,
// the back-end stages, the 3-step reciprocal pixel divide and the output register.
// A stage loads when it is empty or the stage after it moves, so bubbles close
// up and cells keep entering while a result waits on out_stall.
// Synchronous active-low reset clears valids and loads the register defaults.
module spherical_ground_remap_address_unit
  import sgra_pkg::*;
#(
  parameter int GRID_RES      = GRID_RES_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [GRID_W-1:0]    in_grid_x,
  input  logic [GRID_W-1:0]    in_grid_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_source_col,
  output logic [PIX_W-1:0]     out_source_row,
  output logic [GRID_W-1:0]    out_dest_col,
  output logic [GRID_W-1:0]    out_dest_row,
  output logic                 out_hit,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  // floor(n / GRID_RES) == (n * RECIP) >> RECIP_SHIFT, exact for n < 2^34
  localparam logic [63:0] RECIP =
    ((64'd1 << RECIP_SHIFT) + 64'(GRID_RES) - 64'd1) / 64'(GRID_RES);
  localparam logic [RECIP_LO_W-1:0] RECIP_LO = RECIP[RECIP_LO_W-1:0];
  localparam logic [RECIP_HI_W-1:0] RECIP_HI = RECIP[RECIP_W-1:RECIP_LO_W];
  localparam int PROD_W = 26;                 // grid index times span
  localparam int SUM_W  = PROD_W + RECIP_W;
  localparam int QW     = 31;
  localparam int QLSB   = RECIP_SHIFT - 8;    // span is Q8.8, feet are Q.16
  localparam int DBW    = 2 * GRID_W;

  localparam logic [GRID_W-1:0] DMAX = GRID_W'(GRID_RES - 1);
  localparam logic signed [NW-1:0] COL_BIAS = NW'(longint'(GRID_RES / 2) * TWO_PI_Q24);
  localparam logic signed [NW-1:0] ROW_BIAS = NW'(longint'(GRID_RES / 10) * TWO_PI_Q24);
  localparam logic signed [NW-1:0] NEG_P    = -NW'(TWO_PI_Q24);
  localparam logic signed [NW-1:0] LIMIT    = NW'(longint'(1 << PIX_W) * TWO_PI_Q24);

  // ---------------------------------------------------------------- registers
  logic [FRAME_W-1:0]       width_r, height_r;
  logic signed [WORD_W-1:0] az_off_r, el_off_r;
  logic [WORD_W-1:0]        mount_r, span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FRAME_W'(640);
      height_r <= FRAME_W'(480);
      az_off_r <= -16'sd9421;
      el_off_r <= -16'sd12698;
      mount_r  <= 16'd1792;
      span_r   <= 16'd7680;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  width_r  <= cfg_wdata[FRAME_W-1:0];
        CFG_FRAME_HEIGHT: height_r <= cfg_wdata[FRAME_W-1:0];
        CFG_AZ_OFFSET:    az_off_r <= cfg_wdata;
        CFG_EL_OFFSET:    el_off_r <= cfg_wdata;
        CFG_MOUNT_HEIGHT: mount_r  <= cfg_wdata;
        CFG_GROUND_SPAN:  span_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // camera height times CORDIC gain, Q.16; follows the register
  logic [38:0] hk_prod;
  logic [22:0] hk_r;
  assign hk_prod = 39'({mount_r, 6'd0}) * 39'(GAIN_Q16);
  always_ff @(posedge clk) hk_r <= hk_prod[38:16];

  // ---------------------------------------------------------------- front end
  // f0 input, f1 index*span, f2 reciprocal partials, f3 quotient, f4 feet
  localparam int FS = 5;
  logic f_v_r [FS];
  logic f_go  [FS+1];
  logic cp_up_rdy;

  logic [GRID_W-1:0]           f0_gx_r, f0_gy_r;
  logic [DBW-1:0]              f_dst_r [FS];
  logic [PROD_W-1:0]           f1_px_r, f1_py_r;
  logic [PROD_W+RECIP_LO_W-1:0] f2_pxl_r, f2_pyl_r;
  logic [PROD_W+RECIP_HI_W-1:0] f2_pxh_r, f2_pyh_r;
  logic [QW-1:0]               f3_qx_r, f3_qy_r;
  logic signed [31:0]          f4_xg_r, f4_yg_r;

  logic [SUM_W-1:0] sx, sy;
  assign sx = {f2_pxh_r, {RECIP_LO_W{1'b0}}} + SUM_W'(f2_pxl_r);
  assign sy = {f2_pyh_r, {RECIP_LO_W{1'b0}}} + SUM_W'(f2_pyl_r);

  assign f_go[FS] = cp_up_rdy;
  for (genvar i = 0; i < FS; i++) begin : g_fgo
    assign f_go[i] = !f_v_r[i] || f_go[i+1];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        f_v_r[i] <= 1'b0;
      end else if (f_go[i]) begin
        f_v_r[i] <= (i == 0) ? in_valid : f_v_r[(i == 0) ? 0 : i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (f_go[i]) begin
        f_dst_r[i] <= (i == 0) ? {DMAX - in_grid_x, DMAX - in_grid_y}
                               : f_dst_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign in_stall = !f_go[0];

  always_ff @(posedge clk) begin
    if (f_go[0]) begin
      f0_gx_r <= in_grid_x;
      f0_gy_r <= in_grid_y;
    end
    if (f_go[1]) begin
      f1_px_r <= PROD_W'(f0_gx_r) * PROD_W'(span_r);
      f1_py_r <= PROD_W'(f0_gy_r) * PROD_W'(span_r);
    end
    if (f_go[2]) begin
      f2_pxl_r <= (PROD_W+RECIP_LO_W)'(f1_px_r) * (PROD_W+RECIP_LO_W)'(RECIP_LO);
      f2_pyl_r <= (PROD_W+RECIP_LO_W)'(f1_py_r) * (PROD_W+RECIP_LO_W)'(RECIP_LO);
      f2_pxh_r <= (PROD_W+RECIP_HI_W)'(f1_px_r) * (PROD_W+RECIP_HI_W)'(RECIP_HI);
      f2_pyh_r <= (PROD_W+RECIP_HI_W)'(f1_py_r) * (PROD_W+RECIP_HI_W)'(RECIP_HI);
    end
    if (f_go[3]) begin
      f3_qx_r <= sx[QLSB+QW-1:QLSB];
      f3_qy_r <= sy[QLSB+QW-1:QLSB];
    end
    if (f_go[4]) begin
      // lateral feet are centered on the span
      f4_xg_r <= signed'({1'b0, f3_qx_r}) - signed'({9'd0, span_r, 7'd0});
      f4_yg_r <= signed'({1'b0, f3_qy_r});
    end
  end

  // left half-plane: pre-rotate by -pi/2 so CORDIC stays in range
  logic                 xneg;
  logic signed [CW-1:0] cp_x, cp_y;
  logic signed [ZW-1:0] cp_z;
  assign xneg = f4_xg_r[31];
  assign cp_x = xneg ? CW'(f4_yg_r) : CW'(f4_xg_r);
  assign cp_y = xneg ? -CW'(f4_xg_r) : CW'(f4_yg_r);
  assign cp_z = xneg ? ZW'(HALF_PI_Q24) : '0;

  // ---------------------------------------------------------------- azimuth
  logic                 cp_vld, ct_up_rdy;
  logic signed [CW-1:0] cp_mag;
  logic signed [ZW-1:0] cp_phi;
  logic [DBW-1:0]       cp_dst;

  sgra_cordic #(.STAGES(CORDIC_STAGES), .SBW(DBW)) u_phi (
    .clk, .rst_n,
    .in_vld (f_v_r[FS-1]), .up_rdy (cp_up_rdy),
    .in_x (cp_x), .in_y (cp_y), .in_z (cp_z), .in_sb (f_dst_r[FS-1]),
    .out_vld (cp_vld), .dn_rdy (ct_up_rdy),
    .out_x (cp_mag), .out_z (cp_phi), .out_sb (cp_dst)
  );

  // ---------------------------------------------------------------- elevation
  logic                 ct_vld, b_up_rdy;
  logic signed [CW-1:0] ct_mag;
  logic signed [ZW-1:0] ct_z;
  logic [ZW+DBW-1:0]    ct_sb;

  sgra_cordic #(.STAGES(CORDIC_STAGES), .SBW(ZW+DBW)) u_theta (
    .clk, .rst_n,
    .in_vld (cp_vld), .up_rdy (ct_up_rdy),
    .in_x (cp_mag), .in_y (CW'(signed'({1'b0, hk_r}))), .in_z ('0),
    .in_sb ({cp_phi, cp_dst}),
    .out_vld (ct_vld), .dn_rdy (b_up_rdy),
    .out_x (ct_mag), .out_z (ct_z), .out_sb (ct_sb)
  );

  // ---------------------------------------------------------------- back end
  // b0 offsets, b1 times frame size, b2 times 3 plus bias, b3 range clamp
  localparam int BS = 4;
  logic b_v_r [BS];
  logic b_go  [BS+1];
  logic dv_up_rdy;
  logic [DBW-1:0] b_dst_r [BS];

  logic signed [AW-1:0] b0_a_r, b0_b_r;
  logic signed [PW-1:0] b1_a_r, b1_b_r;
  logic signed [NW-1:0] b2_a_r, b2_b_r;
  logic [REM_W-1:0]     b3_a_r, b3_b_r;
  logic                 b3_miss_a_r, b3_miss_b_r;

  assign b_up_rdy  = b_go[0];
  assign b_go[BS]  = dv_up_rdy;
  for (genvar i = 0; i < BS; i++) begin : g_bgo
    assign b_go[i] = !b_v_r[i] || b_go[i+1];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        b_v_r[i] <= 1'b0;
      end else if (b_go[i]) begin
        b_v_r[i] <= (i == 0) ? ct_vld : b_v_r[(i == 0) ? 0 : i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (b_go[i]) begin
        b_dst_r[i] <= (i == 0) ? ct_sb[DBW-1:0] : b_dst_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_go[0]) begin
      b0_a_r <= AW'(signed'(ct_sb[ZW+DBW-1:DBW])) + AW'(signed'({az_off_r, 11'd0}));
      b0_b_r <= AW'(ct_z) + AW'(HALF_PI_Q24) + AW'(signed'({el_off_r, 11'd0}));
    end
    if (b_go[1]) begin
      b1_a_r <= PW'(b0_a_r) * PW'(signed'({1'b0, width_r}));
      b1_b_r <= PW'(b0_b_r) * PW'(signed'({1'b0, height_r}));
    end
    if (b_go[2]) begin
      b2_a_r <= NW'(b1_a_r) + (NW'(b1_a_r) <<< 1) + COL_BIAS;
      b2_b_r <= NW'(b1_b_r) + (NW'(b1_b_r) <<< 1) + ROW_BIAS;
    end
    if (b_go[3]) begin
      // truncation toward zero: anything above -2pi lands on pixel 0
      b3_miss_a_r <= (b2_a_r <= NEG_P) || (b2_a_r >= LIMIT);
      b3_miss_b_r <= (b2_b_r <= NEG_P) || (b2_b_r >= LIMIT);
      b3_a_r <= b2_a_r[NW-1] ? '0 : b2_a_r[REM_W-1:0];
      b3_b_r <= b2_b_r[NW-1] ? '0 : b2_b_r[REM_W-1:0];
    end
  end

  // ---------------------------------------------------------------- divide by 2pi
  logic                    dv_vld, o_go;
  logic [1:0][PIX_W-1:0]   dv_q;
  logic [DBW+1:0]          dv_sb;

  sgra_div #(.DW(REM_W), .QB(PIX_W), .DIV(TWO_PI_Q24), .SBW(DBW+2)) u_div (
    .clk, .rst_n,
    .in_vld (b_v_r[BS-1]), .up_rdy (dv_up_rdy),
    .in_n ({b3_b_r, b3_a_r}),
    .in_sb ({b3_miss_a_r, b3_miss_b_r, b_dst_r[BS-1]}),
    .out_vld (dv_vld), .dn_rdy (o_go),
    .out_q (dv_q), .out_sb (dv_sb)
  );

  // ---------------------------------------------------------------- output
  logic             out_vld_r, hit_r;
  logic [PIX_W-1:0] col_r, row_r;
  logic [DBW-1:0]   dst_r;
  logic             hit_nxt;

  assign o_go = !out_vld_r || !out_stall;
  assign hit_nxt = !dv_sb[DBW+1] && !dv_sb[DBW] &&
                   (FRAME_W'(dv_q[0]) < width_r) && (FRAME_W'(dv_q[1]) < height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (o_go) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (o_go) begin
      hit_r <= hit_nxt;
      col_r <= hit_nxt ? dv_q[0] : '0;
      row_r <= hit_nxt ? dv_q[1] : '0;
      dst_r <= dv_sb[DBW-1:0];
    end
  end

  assign out_valid      = out_vld_r;
  assign out_hit        = hit_r;
  assign out_source_col = col_r;
  assign out_source_row = row_r;
  assign out_dest_col   = dst_r[DBW-1:GRID_W];
  assign out_dest_row   = dst_r[GRID_W-1:0];

endmodule

[src/sgra_checker.sv]
module sgra_checker
  import sgra_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [PIX_W-1:0]  out_source_col,
  input logic [PIX_W-1:0]  out_source_row,
  input logic [GRID_W-1:0] out_dest_col,
  input logic [GRID_W-1:0] out_dest_row,
  input logic              out_hit
);

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_source_col) &&
      $stable(out_source_row) && $stable(out_dest_col) &&
      $stable(out_dest_row) && $stable(out_hit))
    else $error("result changed under stall");

  // a miss carries zero source coordinates
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_source_col == '0 && out_source_row == '0)
    else $error("miss with nonzero source pixel");

  // empty output register means the pipe can take a cell
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // reset flushes the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind spherical_ground_remap_address_unit sgra_checker u_sgra_checker (.*);
